/* src/cvr_pkg.sv */
package cvr_pkg;

   localparam int VECTOR_WIDTH_DEF = 16;
   localparam int CORDIC_STEPS_DEF = 14;
   localparam int GUARD_BITS       = 8;
   localparam int ANGLE_WIDTH      = 32;
   localparam int GAIN_BITS        = 30;
   localparam int SPEED_WIDTH      = 16;
   localparam int TIME_WIDTH       = 16;
   localparam int OPCODE_WIDTH     = 2;
   localparam int STEP_IDX_WIDTH   = 5;

   localparam logic [OPCODE_WIDTH-1:0] OP_ROTATE_LEFT  = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_ROTATE_RIGHT = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_LOAD         = 2'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED       = 2'd3;

   localparam logic [SPEED_WIDTH-1:0]        SPEED_RESET = 16'd12288;
   localparam logic [GAIN_BITS-1:0]          CORDIC_GAIN = 30'd652032874;
   localparam logic signed [ANGLE_WIDTH-1:0] PI_Q28      = 32'sd843314856;
   localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q28 = 32'sd421657428;

   localparam longint DIR_X_RESET   = 8192;
   localparam longint DIR_Y_RESET   = 0;
   localparam longint PLANE_X_RESET = 0;
   localparam longint PLANE_Y_RESET = 5407;

   typedef struct packed {
      logic                          start;
      logic signed [ANGLE_WIDTH-1:0] angle;
   } cordic_cmd_type;

   // atan(2^-i) in Q4.28
   function automatic logic signed [ANGLE_WIDTH-1:0] atan_entry(
      input logic [STEP_IDX_WIDTH-1:0] idx);
      logic signed [ANGLE_WIDTH-1:0] v;
      case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         5'd20: v = 32'sd256;
         5'd21: v = 32'sd128;
         5'd22: v = 32'sd64;
         5'd23: v = 32'sd32;
         5'd24: v = 32'sd16;
         5'd25: v = 32'sd8;
         5'd26: v = 32'sd4;
         5'd27: v = 32'sd2;
         5'd28: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

/* src/cvr_if.sv */
interface cvr_req_if #(parameter int VectorWidth = cvr_pkg::VECTOR_WIDTH_DEF);
   import cvr_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [OPCODE_WIDTH-1:0]       opcode;
   logic [TIME_WIDTH-1:0]         elapsed_time;
   logic signed [VectorWidth-1:0] load_dir_x;
   logic signed [VectorWidth-1:0] load_dir_y;
   logic signed [VectorWidth-1:0] load_plane_x;
   logic signed [VectorWidth-1:0] load_plane_y;

   modport source (output valid, opcode, elapsed_time, load_dir_x, load_dir_y,
                   load_plane_x, load_plane_y, input ready);
   modport sink (input valid, opcode, elapsed_time, load_dir_x, load_dir_y,
                 load_plane_x, load_plane_y, output ready);
endinterface

interface cvr_rsp_if #(parameter int VectorWidth = cvr_pkg::VECTOR_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [VectorWidth-1:0] new_dir_x;
   logic signed [VectorWidth-1:0] new_dir_y;
   logic signed [VectorWidth-1:0] new_plane_x;
   logic signed [VectorWidth-1:0] new_plane_y;

   modport source (output valid, new_dir_x, new_dir_y, new_plane_x, new_plane_y,
                   input ready);
   modport sink (input valid, new_dir_x, new_dir_y, new_plane_x, new_plane_y,
                 output ready);
endinterface

/* src/cvr_angle.sv */
module cvr_angle (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   left,
   input  logic [cvr_pkg::SPEED_WIDTH-1:0]        speed,
   input  logic [cvr_pkg::TIME_WIDTH-1:0]         elapsed_time,
   output logic                                   done,
   output logic signed [cvr_pkg::ANGLE_WIDTH-1:0] angle
);
   import cvr_pkg::*;

   localparam int CntWidth = $clog2(TIME_WIDTH);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CntWidth-1:0]           count_ff, count_in;
   logic [TIME_WIDTH-1:0]         time_ff, time_in;
   logic                          left_ff, left_in;
   logic [ANGLE_WIDTH-1:0]        acc_ff, acc_in;
   logic signed [ANGLE_WIDTH-1:0] angle_ff, angle_in;
   logic [ANGLE_WIDTH-1:0]        acc_next;
   logic signed [ANGLE_WIDTH-1:0] sat;

   // shift-add multiply, one bit of elapsed time per cycle, MSB first
   always_comb begin
      acc_next = {acc_ff[ANGLE_WIDTH-2:0], 1'b0}
               + (time_ff[count_ff] ? ANGLE_WIDTH'(speed) : '0);
      sat      = ($signed({1'b0, acc_next}) > 33'(PI_Q28)) ? PI_Q28 : $signed(acc_next);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      time_in  = time_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      angle_in = angle_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntWidth'(TIME_WIDTH - 1);
         time_in  = elapsed_time;
         left_in  = left;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = acc_next;
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            angle_in = left_ff ? -sat : sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      time_ff  <= time_in;
      left_ff  <= left_in;
      acc_ff   <= acc_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;
endmodule

/* src/cvr_cordic.sv */
module cvr_cordic #(
   parameter int VectorWidth = cvr_pkg::VECTOR_WIDTH_DEF,
   parameter int CordicSteps = cvr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cvr_pkg::cordic_cmd_type       cmd,
   input  logic signed [VectorWidth-1:0] in_x,
   input  logic signed [VectorWidth-1:0] in_y,
   output logic                          done,
   output logic signed [VectorWidth-1:0] out_x,
   output logic signed [VectorWidth-1:0] out_y
);
   import cvr_pkg::*;

   localparam int WorkWidth = VectorWidth + GUARD_BITS + 3;
   localparam int MulWidth  = VectorWidth + 1;
   localparam int ProdWidth = MulWidth + GAIN_BITS;
   localparam int GainShift = GAIN_BITS - GUARD_BITS;
   localparam int FinWidth  = WorkWidth - GUARD_BITS;
   localparam longint SatHiL = (64'sd1 <<< (VectorWidth - 1)) - 64'sd1;
   localparam longint SatLoL = -SatHiL - 64'sd1;
   localparam logic signed [FinWidth-1:0] SatHi = FinWidth'(SatHiL);
   localparam logic signed [FinWidth-1:0] SatLo = FinWidth'(SatLoL);
   localparam logic signed [WorkWidth-1:0] RoundAdd = WorkWidth'(1 << (GUARD_BITS - 1));

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_GAIN = 2'd1;
   localparam logic [1:0] P_ITER = 2'd2;
   localparam logic [1:0] P_FIN  = 2'd3;

   logic [1:0]                    phase_ff, phase_in;
   logic                          done_ff, done_in;
   logic [STEP_IDX_WIDTH-1:0]     count_ff, count_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   logic signed [MulWidth-1:0]    xm_ff, xm_in, ym_ff, ym_in;
   logic signed [ProdWidth-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [WorkWidth-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [VectorWidth-1:0] ox_ff, ox_in, oy_ff, oy_in;

   logic signed [MulWidth-1:0]    sx, sy;
   logic signed [ProdWidth-1:0]   px_next, py_next;
   logic signed [WorkWidth-1:0]   xsh, ysh, xr, yr;
   logic signed [FinWidth-1:0]    fx, fy;
   logic signed [ANGLE_WIDTH-1:0] at;

   always_comb begin
      sx      = MulWidth'(in_x);
      sy      = MulWidth'(in_y);
      px_next = (px_ff <<< 1) + (CORDIC_GAIN[count_ff] ? ProdWidth'(xm_ff) : '0);
      py_next = (py_ff <<< 1) + (CORDIC_GAIN[count_ff] ? ProdWidth'(ym_ff) : '0);
      xsh     = x_ff >>> count_ff;
      ysh     = y_ff >>> count_ff;
      at      = atan_entry(count_ff);
      xr      = (x_ff + RoundAdd) >>> GUARD_BITS;
      yr      = (y_ff + RoundAdd) >>> GUARD_BITS;
      fx      = xr[FinWidth-1:0];
      fy      = yr[FinWidth-1:0];

      phase_in = phase_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      z_in     = z_ff;
      xm_in    = xm_ff;
      ym_in    = ym_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      case (phase_ff)
         P_IDLE: begin
            if (cmd.start) begin
               // quadrant pre-rotation
               if (cmd.angle > HALF_PI_Q28) begin
                  xm_in = -sy;
                  ym_in = sx;
                  z_in  = cmd.angle - HALF_PI_Q28;
               end else if (cmd.angle < -HALF_PI_Q28) begin
                  xm_in = sy;
                  ym_in = -sx;
                  z_in  = cmd.angle + HALF_PI_Q28;
               end else begin
                  xm_in = sx;
                  ym_in = sy;
                  z_in  = cmd.angle;
               end
               px_in    = '0;
               py_in    = '0;
               count_in = STEP_IDX_WIDTH'(GAIN_BITS - 1);
               phase_in = P_GAIN;
            end
         end
         P_GAIN: begin
            px_in    = px_next;
            py_in    = py_next;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               x_in     = WorkWidth'($signed(px_next[ProdWidth-1:GainShift]));
               y_in     = WorkWidth'($signed(py_next[ProdWidth-1:GainShift]));
               count_in = '0;
               phase_in = P_ITER;
            end
         end
         P_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ysh;
               y_in = y_ff + xsh;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ysh;
               y_in = y_ff - xsh;
               z_in = z_ff + at;
            end
            count_in = count_ff + 1'b1;
            if (count_ff == STEP_IDX_WIDTH'(CordicSteps - 1)) begin
               phase_in = P_FIN;
            end
         end
         P_FIN: begin
            ox_in    = (fx > SatHi) ? SatHi[VectorWidth-1:0] :
                       (fx < SatLo) ? SatLo[VectorWidth-1:0] : fx[VectorWidth-1:0];
            oy_in    = (fy > SatHi) ? SatHi[VectorWidth-1:0] :
                       (fy < SatLo) ? SatLo[VectorWidth-1:0] : fy[VectorWidth-1:0];
            done_in  = 1'b1;
            phase_in = P_IDLE;
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in;
      z_ff     <= z_in;
      xm_ff    <= xm_in;
      ym_ff    <= ym_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
   end

   assign done  = done_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
endmodule

/* src/camera_vector_rotation_unit.sv */
// Camera vector rotation unit.
// Holds a camera direction vector and plane vector (signed, VECTOR_WIDTH-3
// fraction bits) and rotates both by rotation_speed * elapsed_time.
// req_chan (valid/ready) takes one request: rotate left, rotate right or load.
// rsp_chan (valid/ready) returns the four vector components after each request.
// csr_write_enable/csr_write_data set rotation_speed (Q4.12 rad/s).
// Load and unused opcodes go straight to S_OUT and the output register. A rotate runs a
// serial angle multiply over the 16 bits of elapsed time, a serial gain
// multiply over the 30 gain bits, then the CORDIC steps, one per iteration.
// One request is processed at a time; the next is taken once the result sits
// in the output register. Rotate time is set by the bit-serial multipliers
// and the iterative CORDIC datapath.
// If rsp_ready stays low, the result holds in the output register; one more
// request is taken, and its result waits in S_OUT until the register drains.
// Reset: rotation_speed = 3.0, direction = (1.0, 0), plane = (0, 0.66).
module camera_vector_rotation_unit #(
   parameter int VECTOR_WIDTH = cvr_pkg::VECTOR_WIDTH_DEF,
   parameter int CORDIC_STEPS = cvr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   cvr_req_if.sink                           req_chan,
   cvr_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [cvr_pkg::SPEED_WIDTH-1:0]   csr_write_data
);
   import cvr_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ANGLE  = 2'd1;
   localparam logic [1:0] S_ROTATE = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [SPEED_WIDTH-1:0]         speed_ff;
   logic signed [VECTOR_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [VECTOR_WIDTH-1:0] px_ff, px_in, py_ff, py_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [VECTOR_WIDTH-1:0] rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic signed [VECTOR_WIDTH-1:0] rpx_ff, rpx_in, rpy_ff, rpy_in;

   logic                           req_take, angle_start, angle_done;
   logic signed [ANGLE_WIDTH-1:0]  angle;
   cordic_cmd_type                 cmd;
   logic                           dir_done, plane_done;
   logic signed [VECTOR_WIDTH-1:0] ndx, ndy, npx, npy;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign angle_start    = req_take && ((req_chan.opcode == OP_ROTATE_LEFT) ||
                                        (req_chan.opcode == OP_ROTATE_RIGHT));
   assign cmd.start      = angle_done;
   assign cmd.angle      = angle;

   cvr_angle u_angle (
      .clock        (clock),
      .reset        (reset),
      .start        (angle_start),
      .left         (req_chan.opcode == OP_ROTATE_LEFT),
      .speed        (speed_ff),
      .elapsed_time (req_chan.elapsed_time),
      .done         (angle_done),
      .angle        (angle)
   );

   cvr_cordic #(.VectorWidth(VECTOR_WIDTH), .CordicSteps(CORDIC_STEPS)) u_dir (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .in_x  (dx_ff),
      .in_y  (dy_ff),
      .done  (dir_done),
      .out_x (ndx),
      .out_y (ndy)
   );

   cvr_cordic #(.VectorWidth(VECTOR_WIDTH), .CordicSteps(CORDIC_STEPS)) u_plane (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .in_x  (px_ff),
      .in_y  (py_ff),
      .done  (plane_done),
      .out_x (npx),
      .out_y (npy)
   );

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      rpx_in       = rpx_ff;
      rpy_in       = rpy_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (angle_start) begin
                  state_in = S_ANGLE;
               end else begin
                  if (req_chan.opcode == OP_LOAD) begin
                     dx_in = req_chan.load_dir_x;
                     dy_in = req_chan.load_dir_y;
                     px_in = req_chan.load_plane_x;
                     py_in = req_chan.load_plane_y;
                  end
                  state_in = S_OUT;
               end
            end
         end
         S_ANGLE: begin
            if (angle_done) begin
               state_in = S_ROTATE;
            end
         end
         S_ROTATE: begin
            if (dir_done) begin
               dx_in    = ndx;
               dy_in    = ndy;
               px_in    = npx;
               py_in    = npy;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rdx_in       = dx_ff;
               rdy_in       = dy_ff;
               rpx_in       = px_ff;
               rpy_in       = py_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= SPEED_RESET;
         dx_ff        <= VECTOR_WIDTH'(DIR_X_RESET);
         dy_ff        <= VECTOR_WIDTH'(DIR_Y_RESET);
         px_ff        <= VECTOR_WIDTH'(PLANE_X_RESET);
         py_ff        <= VECTOR_WIDTH'(PLANE_Y_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            speed_ff <= csr_write_data;
         end
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
      rdx_ff <= rdx_in;
      rdy_ff <= rdy_in;
      rpx_ff <= rpx_in;
      rpy_ff <= rpy_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.new_dir_x   = rdx_ff;
   assign rsp_chan.new_dir_y   = rdy_ff;
   assign rsp_chan.new_plane_x = rpx_ff;
   assign rsp_chan.new_plane_y = rpy_ff;

   a_done_pair: assert property (@(posedge clock) disable iff (reset)
      dir_done == plane_done)
      else $error("cordic units out of step");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      dir_done |-> state_ff == S_ROTATE)
      else $error("cordic result outside rotate");

   a_angle_state: assert property (@(posedge clock) disable iff (reset)
      angle_done |-> state_ff == S_ANGLE)
      else $error("angle result outside angle phase");

   a_rotate_path: assert property (@(posedge clock) disable iff (reset)
      angle_start |=> state_ff == S_ANGLE)
      else $error("rotate request did not start angle phase");
endmodule
